### hdl/ebaf_pkg.sv
// shared constants, types and helpers of the event background activity filter
package ebaf_pkg;

    // support map geometry
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    // field widths
    localparam int X_W  = 9;
    localparam int Y_W  = 9;
    localparam int T_W  = 31;
    localparam int SZ_W = 10;

    // map split into three column banks: column c lives in bank c mod 3
    localparam int NBANK      = 3;
    localparam int COLS3      = (MAX_WIDTH + NBANK - 1) / NBANK;
    localparam int BANK_DEPTH = MAX_HEIGHT * COLS3;
    localparam int AW         = $clog2(BANK_DEPTH);
    localparam int BCW        = $clog2(COLS3);

    // compare width for coordinates against sensor size
    localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CW   = ($clog2(MAXD) + 1 > SZ_W + 1) ? $clog2(MAXD) + 1 : SZ_W + 1;

    // command queue
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PW    = $clog2(CQ_DEPTH);

    // stream widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_T       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_WIDTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_HEIGHT = CFG_IDX_W'(2);

    localparam logic [T_W-1:0]  DELTA_T_RST       = T_W'(7000);
    localparam logic [SZ_W-1:0] SENSOR_WIDTH_RST  = SZ_W'(346);
    localparam logic [SZ_W-1:0] SENSOR_HEIGHT_RST = SZ_W'(260);

    typedef logic [1:0] t_bank;

    // effective sensor size, already clipped to the map
    typedef struct packed {
        logic [CW-1:0] width;
        logic [CW-1:0] height;
    } t_geom;

    // one classified event, ready for the map update
    typedef struct packed {
        logic [X_W-1:0]              x;
        logic [Y_W-1:0]              y;
        logic [T_W-1:0]              t;
        t_bank                       m;        // bank of the event column
        logic                        in_array;
        logic [AW-1:0]               rd_addr;
        logic [AW-1:0]               base;     // row y start inside a bank
        logic [2:0]                  row_ok;   // rows y-1, y, y+1 inside sensor
        logic [NBANK-1:0]            col_ok;   // per bank, strip column inside sensor
        logic [NBANK-1:0][BCW-1:0]   bcol;     // per bank, strip column index
    } t_cmd;

    typedef struct packed {
        logic           is_signal;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } t_result;

    // floor(v / 3) by reciprocal multiply, exact for v below 4096
    function automatic logic [X_W-1:0] div3(input logic [X_W-1:0] v);
        logic [X_W+11:0] p;
        p = (X_W + 12)'(v) * (X_W + 12)'(2731);
        return X_W'(p >> 13);
    endfunction

endpackage

### hdl/ebaf_front.sv
// front part: takes events, works out bank, addresses and neighbour masks
module ebaf_front (
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [ebaf_pkg::X_W-1:0] i_pixel_x,
    input  logic [ebaf_pkg::Y_W-1:0] i_pixel_y,
    input  logic [ebaf_pkg::T_W-1:0] i_event_time,
    input  ebaf_pkg::t_geom         i_geom,
    input  logic                    i_full,
    input  logic                    i_clearing,
    output logic                    o_push,
    output ebaf_pkg::t_cmd          o_cmd
);

    logic [ebaf_pkg::X_W-1:0] xq;
    logic [ebaf_pkg::X_W-1:0] xq3;
    logic [ebaf_pkg::X_W-1:0] rem;
    ebaf_pkg::t_bank          m;
    ebaf_pkg::t_bank          mm1;
    logic [ebaf_pkg::CW-1:0]  xc;
    logic [ebaf_pkg::CW-1:0]  yc;
    logic                     mid_ok;
    logic                     left_ok;
    logic                     right_ok;
    logic [ebaf_pkg::AW-1:0]  base;

    always_comb begin
        xq  = ebaf_pkg::div3(i_pixel_x);
        xq3 = ebaf_pkg::X_W'({xq, 1'b0}) + xq;
        rem = i_pixel_x - xq3;
        m   = rem[1:0];
        mm1 = (m == 2'd0) ? 2'd2 : m - 2'd1;

        xc = ebaf_pkg::CW'(i_pixel_x);
        yc = ebaf_pkg::CW'(i_pixel_y);

        mid_ok   = xc < i_geom.width;
        left_ok  = (xc != '0) && (xc <= i_geom.width);
        right_ok = (xc + ebaf_pkg::CW'(1)) < i_geom.width;

        base = ebaf_pkg::AW'(ebaf_pkg::AW'(i_pixel_y) * ebaf_pkg::AW'(ebaf_pkg::COLS3));

        o_cmd.x        = i_pixel_x;
        o_cmd.y        = i_pixel_y;
        o_cmd.t        = i_event_time;
        o_cmd.m        = m;
        o_cmd.in_array = (xc < ebaf_pkg::CW'(ebaf_pkg::MAX_WIDTH))
                      && (yc < ebaf_pkg::CW'(ebaf_pkg::MAX_HEIGHT));
        o_cmd.base     = base;
        o_cmd.rd_addr  = base + ebaf_pkg::AW'(xq);
        o_cmd.row_ok[0] = (yc != '0) && (yc <= i_geom.height);
        o_cmd.row_ok[1] = yc < i_geom.height;
        o_cmd.row_ok[2] = (yc + ebaf_pkg::CW'(1)) < i_geom.height;

        // each bank holds exactly one column of the x-1..x+1 strip
        for (int b = 0; b < ebaf_pkg::NBANK; b++) begin
            if (m == 2'(b)) begin
                o_cmd.bcol[b]   = ebaf_pkg::BCW'(xq);
                o_cmd.col_ok[b] = mid_ok;
            end else if (mm1 == 2'(b)) begin
                o_cmd.bcol[b]   = (m == 2'd0) ? ebaf_pkg::BCW'(xq - ebaf_pkg::X_W'(1))
                                              : ebaf_pkg::BCW'(xq);
                o_cmd.col_ok[b] = left_ok;
            end else begin
                o_cmd.bcol[b]   = (m == 2'd2) ? ebaf_pkg::BCW'(xq + ebaf_pkg::X_W'(1))
                                              : ebaf_pkg::BCW'(xq);
                o_cmd.col_ok[b] = right_ok;
            end
        end
    end

    assign o_ready = !i_full && !i_clearing;
    assign o_push  = i_valid && o_ready;

endmodule

### hdl/ebaf_cmd_fifo.sv
// short command queue between front and back part
module ebaf_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ebaf_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output ebaf_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);

    ebaf_pkg::t_cmd              r_mem [ebaf_pkg::CQ_DEPTH];
    logic [ebaf_pkg::CQ_PW-1:0]  r_wp;
    logic [ebaf_pkg::CQ_PW-1:0]  r_rp;
    logic [ebaf_pkg::CQ_PW:0]    r_cnt;
    logic [ebaf_pkg::CQ_PW:0]    n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (ebaf_pkg::CQ_PW + 1)'(ebaf_pkg::CQ_DEPTH));

endmodule

### hdl/ebaf_back.sv
// back part: support map banks, judgement and neighbour update, result buffer
module ebaf_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  ebaf_pkg::t_cmd           i_head,
    output logic                     o_pop,
    input  logic [ebaf_pkg::T_W-1:0] i_delta_t,
    output logic                     o_clearing,
    output logic                     o_valid,
    input  logic                     i_ready,
    output ebaf_pkg::t_result        o_result
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_ROW0  = 4'b0010,
        ST_ROW1  = 4'b0100,
        ST_ROW2  = 4'b1000
    } t_bk_state;

    t_bk_state                 r_state;
    t_bk_state                 n_state;
    logic [ebaf_pkg::AW-1:0]   r_clr_addr;
    ebaf_pkg::t_cmd            r_cmd;
    ebaf_pkg::t_cmd            cur;

    logic [ebaf_pkg::T_W-1:0]  r_mem [ebaf_pkg::NBANK][ebaf_pkg::BANK_DEPTH];
    logic [ebaf_pkg::T_W-1:0]  r_rd  [ebaf_pkg::NBANK];

    ebaf_pkg::t_result         r_ob [2];
    logic                      r_ob_wp;
    logic                      r_ob_rp;
    logic [1:0]                r_ob_cnt;

    logic                                      start;
    logic                                      row_act;
    logic [ebaf_pkg::AW-1:0]                   row_base;
    logic [ebaf_pkg::NBANK-1:0]                we;
    logic [ebaf_pkg::NBANK-1:0][ebaf_pkg::AW-1:0] wa;
    logic [ebaf_pkg::T_W-1:0]                  wd;
    logic                                      re;
    logic [ebaf_pkg::AW-1:0]                   ra;
    logic [ebaf_pkg::T_W-1:0]                  rd_sel;
    logic [ebaf_pkg::T_W-1:0]                  last;
    logic [ebaf_pkg::T_W:0]                    diff;
    logic                                      noise;
    logic                                      push;
    logic                                      pop;
    ebaf_pkg::t_result                         res;

    // start an event only with a free result slot for it
    assign start = (r_state == ST_ROW0) && !i_empty && (r_ob_cnt != 2'd2);
    assign o_pop = start;
    assign push  = (r_state == ST_ROW1);
    assign pop   = (r_ob_cnt != 2'd0) && i_ready;
    assign cur   = (r_state == ST_ROW0) ? i_head : r_cmd;
    assign re    = start && i_head.in_array;
    assign ra    = i_head.rd_addr;

    always_comb begin
        row_base = '0;
        row_act  = 1'b0;
        case (r_state)
            ST_ROW0: begin
                row_base = i_head.base - ebaf_pkg::AW'(ebaf_pkg::COLS3);
                row_act  = start && i_head.row_ok[0];
            end
            ST_ROW1: begin
                row_base = r_cmd.base;
                row_act  = r_cmd.row_ok[1];
            end
            ST_ROW2: begin
                row_base = r_cmd.base + ebaf_pkg::AW'(ebaf_pkg::COLS3);
                row_act  = r_cmd.row_ok[2];
            end
            default: begin
                row_base = '0;
                row_act  = 1'b0;
            end
        endcase

        for (int b = 0; b < ebaf_pkg::NBANK; b++) begin
            if (r_state == ST_CLEAR) begin
                we[b] = 1'b1;
                wa[b] = r_clr_addr;
            end else begin
                // the event pixel itself is never written
                we[b] = row_act && cur.col_ok[b]
                     && !((r_state == ST_ROW1) && (cur.m == 2'(b)));
                wa[b] = row_base + ebaf_pkg::AW'(cur.bcol[b]);
            end
        end
        wd = (r_state == ST_CLEAR) ? '0 : cur.t;
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < ebaf_pkg::NBANK; b++) begin
            if (we[b]) begin
                r_mem[b][wa[b]] <= wd;
            end
            if (re) begin
                r_rd[b] <= r_mem[b][ra];
            end
        end
    end

    // judgement, in the cycle after the read
    always_comb begin
        case (r_cmd.m)
            2'd0:    rd_sel = r_rd[0];
            2'd1:    rd_sel = r_rd[1];
            2'd2:    rd_sel = r_rd[2];
            default: rd_sel = '0;
        endcase
        last  = r_cmd.in_array ? rd_sel : '0;
        diff  = {1'b0, r_cmd.t} - {1'b0, last};
        noise = (last == '0) || ($signed(diff) >= $signed({1'b0, i_delta_t}));
        res.is_signal = !noise;
        res.x         = r_cmd.x;
        res.y         = r_cmd.y;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ebaf_pkg::AW'(ebaf_pkg::BANK_DEPTH - 1)) begin
                    n_state = ST_ROW0;
                end
            end
            ST_ROW0: begin
                if (start) begin
                    n_state = ST_ROW1;
                end
            end
            ST_ROW1: n_state = ST_ROW2;
            ST_ROW2: n_state = ST_ROW0;
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_ob_wp    <= 1'b0;
            r_ob_rp    <= 1'b0;
            r_ob_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (push) begin
                r_ob_wp <= !r_ob_wp;
            end
            if (pop) begin
                r_ob_rp <= !r_ob_rp;
            end
            r_ob_cnt <= r_ob_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd <= i_head;
        end
        if (push) begin
            r_ob[r_ob_wp] <= res;
        end
    end

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_valid    = (r_ob_cnt != 2'd0);
    assign o_result   = r_ob[r_ob_rp];

    a_no_self_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        re |-> !(we[i_head.m] && (wa[i_head.m] == ra)))
        else $error("neighbour write hits the pixel being read");

    a_push_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> push)
        else $error("result not produced one cycle after start");

    a_ob_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_ob_cnt != 2'd2))
        else $error("result buffer overflow");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_clearing) |->
            ($past(r_clr_addr) == ebaf_pkg::AW'(ebaf_pkg::BANK_DEPTH - 1)))
        else $error("clearing pass ended early");

endmodule

### hdl/event_background_activity_filter.sv
// top level of the event background activity filter with its config registers
// path: an event passes the command queue, the map read and the result buffer in turn
// update: the back part takes a new event only once the 3x3 update of the last is written,
//   one neighbour row per cycle over three column banks of the support map
// reset: synchronous, active low; afterwards a clearing pass zeroes the map, one word
//   of each bank a cycle, while events are held off and config writes go on
module event_background_activity_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // event in: pixel_x [8:0], pixel_y [17:9], event_time [48:18], zero pad above
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ebaf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // result out: out_x [8:0], out_y [17:9], zero pad above
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ebaf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // result flag: is_signal [0]
    output logic                               m_axis_tuser,
    // register write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ebaf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ebaf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // config registers
    logic [ebaf_pkg::T_W-1:0]  r_delta_t;
    logic [ebaf_pkg::SZ_W-1:0] r_sensor_width;
    logic [ebaf_pkg::SZ_W-1:0] r_sensor_height;

    ebaf_pkg::t_geom           geom;
    ebaf_pkg::t_cmd            fe_cmd;
    ebaf_pkg::t_cmd            q_head;
    ebaf_pkg::t_result         result;
    logic                      fe_push;
    logic                      q_empty;
    logic                      q_full;
    logic                      bk_pop;
    logic                      bk_clearing;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta_t       <= ebaf_pkg::DELTA_T_RST;
            r_sensor_width  <= ebaf_pkg::SENSOR_WIDTH_RST;
            r_sensor_height <= ebaf_pkg::SENSOR_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ebaf_pkg::CFG_DELTA_T:       r_delta_t       <= i_cfg_data[ebaf_pkg::T_W-1:0];
                ebaf_pkg::CFG_SENSOR_WIDTH:  r_sensor_width  <= i_cfg_data[ebaf_pkg::SZ_W-1:0];
                ebaf_pkg::CFG_SENSOR_HEIGHT: r_sensor_height <= i_cfg_data[ebaf_pkg::SZ_W-1:0];
                default: begin
                    // indexes past the register list are ignored
                end
            endcase
        end
    end

    // sensor size clipped to the map
    always_comb begin
        geom.width  = (ebaf_pkg::CW'(r_sensor_width) > ebaf_pkg::CW'(ebaf_pkg::MAX_WIDTH))
                    ? ebaf_pkg::CW'(ebaf_pkg::MAX_WIDTH) : ebaf_pkg::CW'(r_sensor_width);
        geom.height = (ebaf_pkg::CW'(r_sensor_height) > ebaf_pkg::CW'(ebaf_pkg::MAX_HEIGHT))
                    ? ebaf_pkg::CW'(ebaf_pkg::MAX_HEIGHT) : ebaf_pkg::CW'(r_sensor_height);
    end

    // front: unpack and classify the item
    ebaf_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_pixel_x    (s_axis_tdata[ebaf_pkg::X_W-1:0]),
        .i_pixel_y    (s_axis_tdata[ebaf_pkg::X_W+ebaf_pkg::Y_W-1:ebaf_pkg::X_W]),
        .i_event_time (s_axis_tdata[ebaf_pkg::X_W+ebaf_pkg::Y_W+ebaf_pkg::T_W-1:
                                    ebaf_pkg::X_W+ebaf_pkg::Y_W]),
        .i_geom       (geom),
        .i_full       (q_full),
        .i_clearing   (bk_clearing),
        .o_push       (fe_push),
        .o_cmd        (fe_cmd)
    );

    // decouples event intake from the map update
    ebaf_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_cmd   (fe_cmd),
        .i_pop   (bk_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: read support time, judge, write the eight neighbours
    ebaf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_head     (q_head),
        .o_pop      (bk_pop),
        .i_delta_t  (r_delta_t),
        .o_clearing (bk_clearing),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (result)
    );

    assign m_axis_tuser = result.is_signal;
    assign m_axis_tdata = {{(ebaf_pkg::OUT_TDATA_W - ebaf_pkg::X_W - ebaf_pkg::Y_W){1'b0}},
                           result.y, result.x};

endmodule
